// File: src/lkvc_pkg.sv
// Package with shared types and constants for the LRU key-value cache.
package lkvc_pkg;

   // Default sizing of the store.
   localparam int DEFAULT_ENTRIES = 16;
   localparam int DEFAULT_KEY_BITS = 32;

   // Slot fields in shared structs are sized for the largest store.
   localparam int SLOT_MAX_BITS = 8;

   // Capacity register.
   localparam int CAPACITY_BITS = 5;
   localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 5'd10;
   localparam logic [CAPACITY_BITS-1:0] CAPACITY_DEFAULT = 5'd10;

   // Operation codes.
   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_SET = 1'b1;

   // Value returned by a get that misses.
   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

   // One request.
   typedef struct packed {
      logic mode;
      logic signed [31:0] lookup_key;
      logic signed [31:0] data_in;
   } req_type;

   // One result.
   typedef struct packed {
      logic found;
      logic signed [31:0] data_out;
   } rsp_type;

   // Outcome of the associative search.
   typedef struct packed {
      logic hit;
      logic [SLOT_MAX_BITS-1:0] hit_slot;
      logic [SLOT_MAX_BITS-1:0] free_slot;
      logic [SLOT_MAX_BITS-1:0] victim_slot;
   } match_type;

endpackage

// File: src/lkvc_match.sv
// Associative key search, free slot pick and least recent victim pick.
module lkvc_match #(
   parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES,
   parameter int KEY_BITS = lkvc_pkg::DEFAULT_KEY_BITS,
   localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic [KEY_BITS-1:0] key,
   input  logic [ENTRIES-1:0][KEY_BITS-1:0] keys,
   input  logic [ENTRIES-1:0] valid,
   input  logic [ENTRIES-1:0][SLOT_BITS-1:0] order,
   output lkvc_pkg::match_type match
);

   logic [ENTRIES-1:0] key_hit;
   logic [ENTRIES-1:0] order_valid;

   // Compare the key against every valid entry at once.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_hit[i] = valid[i] && (keys[i] == key);
         order_valid[i] = valid[order[i]];
      end
   end

   // Lowest matching slot, lowest free slot, and the valid slot nearest
   // the least recent end of the order.
   always_comb begin
      match = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (key_hit[i]) begin
            match.hit = 1'b1;
            match.hit_slot = lkvc_pkg::SLOT_MAX_BITS'(i);
         end
         if (!valid[i]) begin
            match.free_slot = lkvc_pkg::SLOT_MAX_BITS'(i);
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (order_valid[i]) begin
            match.victim_slot = lkvc_pkg::SLOT_MAX_BITS'(order[i]);
         end
      end
   end

endmodule

// File: src/lkvc_recency.sv
// Recency order register, most recent slot first.
module lkvc_recency #(
   parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES,
   localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic clock,
   input  logic reset,
   input  logic touch,
   input  logic [SLOT_BITS-1:0] touch_slot,
   output logic [ENTRIES-1:0][SLOT_BITS-1:0] order
);

   logic [ENTRIES-1:0][SLOT_BITS-1:0] order_ff;
   logic [ENTRIES-1:0][SLOT_BITS-1:0] order_in;
   logic [ENTRIES-1:0] slot_at;

   // Find where the touched slot sits in the order.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         slot_at[i] = (order_ff[i] == touch_slot);
      end
   end

   // Move the touched slot to the front; positions up to its old place
   // shift back by one.
   always_comb begin
      order_in = order_ff;
      if (touch) begin
         order_in[0] = touch_slot;
         for (int i = 1; i < ENTRIES; i++) begin
            if (|(slot_at >> i)) begin
               order_in[i] = order_ff[i-1];
            end
         end
      end
   end

   // Reset to the identity order.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            order_ff[i] <= SLOT_BITS'(i);
         end
      end else begin
         order_ff <= order_in;
      end
   end

   assign order = order_ff;

endmodule

// File: src/lru_key_value_cache_top.sv
// Top level of the fully associative key-value cache with LRU replacement.
//
// Requests enter on req_data when start is high and busy is low. busy stays
// low, so a request can be taken in every clock cycle. Each request is a get
// (mode 0) or a set (mode 1) of lookup_key, with data_in stored by a set.
// The request is registered, searched against all entries in the following
// cycle, and its result is registered at the end of that cycle: rsp_strobe
// and rsp_data rise as the result register loads, last one cycle and are
// taken at the end of that cycle.
// Throughput is one request per cycle; the state update of one request is
// complete before the next registered request is searched.
// The receiver cannot stall; each result is taken in its strobe cycle.
// The capacity register is written through csr_valid/csr_ready/csr_data and
// only takes effect while the store is empty; otherwise the write is dropped.
// Capacity zero means ten entries, and a capacity above the store size uses
// the whole store.
// Synchronous reset clears all valid marks and the fill count, restores the
// identity recency order and sets capacity to ten.
module lru_key_value_cache_top #(
   parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES,
   parameter int KEY_BITS = lkvc_pkg::DEFAULT_KEY_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  lkvc_pkg::req_type req_data,
   output logic rsp_strobe,
   output lkvc_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [lkvc_pkg::CAPACITY_BITS-1:0] csr_data
);

   localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int CAP_W = (CNT_BITS > lkvc_pkg::CAPACITY_BITS) ?
                          CNT_BITS : lkvc_pkg::CAPACITY_BITS;

   logic req_valid_ff;
   lkvc_pkg::req_type req_ff;
   logic rsp_strobe_ff;
   logic rsp_strobe_in;
   lkvc_pkg::rsp_type rsp_ff;
   logic [lkvc_pkg::CAPACITY_BITS-1:0] capacity_ff;
   logic [lkvc_pkg::CAPACITY_BITS-1:0] capacity_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [ENTRIES-1:0][KEY_BITS-1:0] keys_ff;
   logic [31:0] values_ff [ENTRIES];

   logic [63:0] key_wide;
   logic [KEY_BITS-1:0] key;
   logic [ENTRIES-1:0][SLOT_BITS-1:0] order;
   lkvc_pkg::match_type match;
   logic [CAP_W-1:0] cap_raw;
   logic [CAP_W-1:0] cap_eff;
   logic has_room;
   logic is_set;
   logic [SLOT_BITS-1:0] slot;
   logic touch;
   logic insert;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_ff <= req_data;
   end

   // Keys are compared in their low KEY_BITS bits.
   assign key_wide = {32'h0, req_ff.lookup_key};
   assign key = key_wide[KEY_BITS-1:0];

   lkvc_match #(
      .ENTRIES(ENTRIES),
      .KEY_BITS(KEY_BITS)
   ) u_match (
      .key(key),
      .keys(keys_ff),
      .valid(valid_ff),
      .order(order),
      .match(match)
   );

   // Effective capacity: zero means the default, and the store size caps it.
   always_comb begin
      cap_raw = CAP_W'(capacity_ff);
      if (cap_raw == '0) begin
         cap_raw = CAP_W'(lkvc_pkg::CAPACITY_DEFAULT);
      end
      cap_eff = cap_raw;
      if (cap_raw > CAP_W'(ENTRIES)) begin
         cap_eff = CAP_W'(ENTRIES);
      end
   end

   assign has_room = CAP_W'(count_ff) < cap_eff;
   assign is_set = (req_ff.mode == lkvc_pkg::MODE_SET);

   // Slot for this request: the hit slot, a free slot, or the victim.
   always_comb begin
      if (match.hit) begin
         slot = match.hit_slot[SLOT_BITS-1:0];
      end else if (has_room) begin
         slot = match.free_slot[SLOT_BITS-1:0];
      end else begin
         slot = match.victim_slot[SLOT_BITS-1:0];
      end
   end

   assign touch = req_valid_ff && (match.hit || is_set);
   assign insert = req_valid_ff && is_set && !match.hit;

   lkvc_recency #(
      .ENTRIES(ENTRIES)
   ) u_recency (
      .clock(clock),
      .reset(reset),
      .touch(touch),
      .touch_slot(slot),
      .order(order)
   );

   // Valid marks and fill count; the count only grows into a free slot.
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (insert) begin
         valid_in[slot] = 1'b1;
         if (has_room) begin
            count_in = count_ff + CNT_BITS'(1);
         end
      end
   end

   // Capacity is written only while the store holds nothing.
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_valid && csr_ready && (count_ff == '0)) begin
         capacity_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         capacity_ff <= lkvc_pkg::CAPACITY_RESET;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         capacity_ff <= capacity_in;
      end
   end

   // Entry storage: a set writes the value, a new key also writes the key.
   always_ff @(posedge clock) begin
      if (req_valid_ff && is_set) begin
         values_ff[slot] <= req_ff.data_in;
      end
      if (insert) begin
         keys_ff[slot] <= key;
      end
   end

   assign rsp_strobe_in = req_valid_ff;

   // Result register; a get hit reads the stored value at the clock edge.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff.found <= match.hit;
      if (is_set) begin
         rsp_ff.data_out <= req_ff.data_in;
      end else if (match.hit) begin
         rsp_ff.data_out <= values_ff[match.hit_slot[SLOT_BITS-1:0]];
      end else begin
         rsp_ff.data_out <= lkvc_pkg::MISS_VALUE;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

`ifndef ASSERT_OFF
   // The fill count always matches the number of valid entries.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      CNT_BITS'($countones(valid_ff)) == count_ff)
      else $error("fill count differs from valid entries");

   // The store never holds more entries than the effective capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CAP_W'(count_ff) <= cap_eff)
      else $error("fill count above capacity");

   // Every registered request yields a result strobe in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_strobe)
      else $error("request produced no result");

   // A set that misses must land in an invalid slot, or evict a valid one
   // only when the fill count has reached the effective capacity.
   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      (insert && valid_ff[slot]) |-> !has_room)
      else $error("valid entry evicted while room was left");
`endif

endmodule
